// File: hdl/rqmf_pkg.sv
// ----------------------------------------------------------------------------
// rqmf_pkg: shared types and constants of the read quality and motif filter
// Holds the beat and verdict payloads, the configuration record, register
// indexes and the Phred error probability table in Q1.40.
// ----------------------------------------------------------------------------
package rqmf_pkg;

    // Fixed sizes of the read filter.
    localparam int MAX_PATTERN_LEN_DEF = 64;
    localparam int MAX_UNIT_LEN        = 8;
    localparam int QUEUE_DEPTH_DEF     = 2;
    localparam int PROB_FRAC_BITS      = 40;
    localparam int COUNT_W             = 21;
    localparam int SUM_W               = 64;
    localparam int PROB_W              = 41;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 64;

    localparam logic [COUNT_W-1:0] MAX_READ_LEN = 21'd1048576;
    localparam logic [7:0]         PHRED_OFFSET = 8'd33;
    localparam logic [7:0]         PHRED_TOP    = 8'd127;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_READ_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MEAN_ERROR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_UNIT_CHARS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_UNIT_LENGTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_UNIT_CHARS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_UNIT_LENGTH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_COPIES       = 3'd6;

    // One base of a read.
    typedef struct packed {
        logic [7:0] base_char;
        logic [7:0] quality_char;
        logic       last_base;
    } base_beat_t;

    // Verdict of one read.
    typedef struct packed {
        logic               keep_read;
        logic [COUNT_W-1:0] read_length;
        logic               length_ok;
        logic               quality_ok;
        logic               left_found;
        logic               right_found;
    } verdict_t;

    // Totals of a finished read, handed from the front to the back.
    typedef struct packed {
        logic [COUNT_W-1:0] base_count;
        logic [SUM_W-1:0]   error_sum;
        logic               left_seen;
        logic               right_seen;
    } read_totals_t;

    // Configuration record.
    typedef struct packed {
        logic [COUNT_W-1:0] min_read_length;
        logic [PROB_W-1:0]  max_mean_error;
        logic [63:0]        left_unit_chars;
        logic [3:0]         left_unit_length;
        logic [63:0]        right_unit_chars;
        logic [3:0]         right_unit_length;
        logic [6:0]         unit_copies;
    } cfg_t;

    // Q1.40 values of 10^(-k/10) for k = 0..9.
    localparam logic [63:0] D0 = 64'd1099511627776;
    localparam logic [63:0] D1 = 64'd873373130350;
    localparam logic [63:0] D2 = 64'd693744936887;
    localparam logic [63:0] D3 = 64'd551061191066;
    localparam logic [63:0] D4 = 64'd437723463125;
    localparam logic [63:0] D5 = 64'd347696105761;
    localparam logic [63:0] D6 = 64'd276184833910;
    localparam logic [63:0] D7 = 64'd219381411577;
    localparam logic [63:0] D8 = 64'd174260849389;
    localparam logic [63:0] D9 = 64'd138420312877;

    // Powers of ten for the decades.
    localparam logic [63:0] T1  = 64'd10;
    localparam logic [63:0] T2  = 64'd100;
    localparam logic [63:0] T3  = 64'd1000;
    localparam logic [63:0] T4  = 64'd10000;
    localparam logic [63:0] T5  = 64'd100000;
    localparam logic [63:0] T6  = 64'd1000000;
    localparam logic [63:0] T7  = 64'd10000000;
    localparam logic [63:0] T8  = 64'd100000000;
    localparam logic [63:0] T9  = 64'd1000000000;
    localparam logic [63:0] T10 = 64'd10000000000;
    localparam logic [63:0] T11 = 64'd100000000000;
    localparam logic [63:0] T12 = 64'd1000000000000;

    // Error probability of each Phred score, rounded half up.
    localparam logic [PROB_W-1:0] ERROR_ROM [128] = '{
        41'(D0), 41'(D1), 41'(D2), 41'(D3), 41'(D4),
        41'(D5), 41'(D6), 41'(D7), 41'(D8), 41'(D9),
        41'((D0 + T1 / 2) / T1), 41'((D1 + T1 / 2) / T1), 41'((D2 + T1 / 2) / T1),
        41'((D3 + T1 / 2) / T1), 41'((D4 + T1 / 2) / T1), 41'((D5 + T1 / 2) / T1),
        41'((D6 + T1 / 2) / T1), 41'((D7 + T1 / 2) / T1), 41'((D8 + T1 / 2) / T1),
        41'((D9 + T1 / 2) / T1),
        41'((D0 + T2 / 2) / T2), 41'((D1 + T2 / 2) / T2), 41'((D2 + T2 / 2) / T2),
        41'((D3 + T2 / 2) / T2), 41'((D4 + T2 / 2) / T2), 41'((D5 + T2 / 2) / T2),
        41'((D6 + T2 / 2) / T2), 41'((D7 + T2 / 2) / T2), 41'((D8 + T2 / 2) / T2),
        41'((D9 + T2 / 2) / T2),
        41'((D0 + T3 / 2) / T3), 41'((D1 + T3 / 2) / T3), 41'((D2 + T3 / 2) / T3),
        41'((D3 + T3 / 2) / T3), 41'((D4 + T3 / 2) / T3), 41'((D5 + T3 / 2) / T3),
        41'((D6 + T3 / 2) / T3), 41'((D7 + T3 / 2) / T3), 41'((D8 + T3 / 2) / T3),
        41'((D9 + T3 / 2) / T3),
        41'((D0 + T4 / 2) / T4), 41'((D1 + T4 / 2) / T4), 41'((D2 + T4 / 2) / T4),
        41'((D3 + T4 / 2) / T4), 41'((D4 + T4 / 2) / T4), 41'((D5 + T4 / 2) / T4),
        41'((D6 + T4 / 2) / T4), 41'((D7 + T4 / 2) / T4), 41'((D8 + T4 / 2) / T4),
        41'((D9 + T4 / 2) / T4),
        41'((D0 + T5 / 2) / T5), 41'((D1 + T5 / 2) / T5), 41'((D2 + T5 / 2) / T5),
        41'((D3 + T5 / 2) / T5), 41'((D4 + T5 / 2) / T5), 41'((D5 + T5 / 2) / T5),
        41'((D6 + T5 / 2) / T5), 41'((D7 + T5 / 2) / T5), 41'((D8 + T5 / 2) / T5),
        41'((D9 + T5 / 2) / T5),
        41'((D0 + T6 / 2) / T6), 41'((D1 + T6 / 2) / T6), 41'((D2 + T6 / 2) / T6),
        41'((D3 + T6 / 2) / T6), 41'((D4 + T6 / 2) / T6), 41'((D5 + T6 / 2) / T6),
        41'((D6 + T6 / 2) / T6), 41'((D7 + T6 / 2) / T6), 41'((D8 + T6 / 2) / T6),
        41'((D9 + T6 / 2) / T6),
        41'((D0 + T7 / 2) / T7), 41'((D1 + T7 / 2) / T7), 41'((D2 + T7 / 2) / T7),
        41'((D3 + T7 / 2) / T7), 41'((D4 + T7 / 2) / T7), 41'((D5 + T7 / 2) / T7),
        41'((D6 + T7 / 2) / T7), 41'((D7 + T7 / 2) / T7), 41'((D8 + T7 / 2) / T7),
        41'((D9 + T7 / 2) / T7),
        41'((D0 + T8 / 2) / T8), 41'((D1 + T8 / 2) / T8), 41'((D2 + T8 / 2) / T8),
        41'((D3 + T8 / 2) / T8), 41'((D4 + T8 / 2) / T8), 41'((D5 + T8 / 2) / T8),
        41'((D6 + T8 / 2) / T8), 41'((D7 + T8 / 2) / T8), 41'((D8 + T8 / 2) / T8),
        41'((D9 + T8 / 2) / T8),
        41'((D0 + T9 / 2) / T9), 41'((D1 + T9 / 2) / T9), 41'((D2 + T9 / 2) / T9),
        41'((D3 + T9 / 2) / T9), 41'((D4 + T9 / 2) / T9), 41'((D5 + T9 / 2) / T9),
        41'((D6 + T9 / 2) / T9), 41'((D7 + T9 / 2) / T9), 41'((D8 + T9 / 2) / T9),
        41'((D9 + T9 / 2) / T9),
        41'((D0 + T10 / 2) / T10), 41'((D1 + T10 / 2) / T10), 41'((D2 + T10 / 2) / T10),
        41'((D3 + T10 / 2) / T10), 41'((D4 + T10 / 2) / T10), 41'((D5 + T10 / 2) / T10),
        41'((D6 + T10 / 2) / T10), 41'((D7 + T10 / 2) / T10), 41'((D8 + T10 / 2) / T10),
        41'((D9 + T10 / 2) / T10),
        41'((D0 + T11 / 2) / T11), 41'((D1 + T11 / 2) / T11), 41'((D2 + T11 / 2) / T11),
        41'((D3 + T11 / 2) / T11), 41'((D4 + T11 / 2) / T11), 41'((D5 + T11 / 2) / T11),
        41'((D6 + T11 / 2) / T11), 41'((D7 + T11 / 2) / T11), 41'((D8 + T11 / 2) / T11),
        41'((D9 + T11 / 2) / T11),
        41'((D0 + T12 / 2) / T12), 41'((D1 + T12 / 2) / T12), 41'((D2 + T12 / 2) / T12),
        41'((D3 + T12 / 2) / T12), 41'((D4 + T12 / 2) / T12), 41'((D5 + T12 / 2) / T12),
        41'((D6 + T12 / 2) / T12), 41'((D7 + T12 / 2) / T12)
    };

endpackage

// File: hdl/rqmf_cfg_regs.sv
// ----------------------------------------------------------------------------
// rqmf_cfg_regs: configuration registers
// Takes register writes by index and holds the filter settings.
// ----------------------------------------------------------------------------
module rqmf_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rqmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rqmf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rqmf_pkg::cfg_t                      cfg
);
    import rqmf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Decode a write beat into the addressed field.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_READ_LENGTH:   cfg_next.min_read_length   = cfg_data[COUNT_W-1:0];
                CFG_MAX_MEAN_ERROR:    cfg_next.max_mean_error    = cfg_data[PROB_W-1:0];
                CFG_LEFT_UNIT_CHARS:   cfg_next.left_unit_chars   = cfg_data;
                CFG_LEFT_UNIT_LENGTH:  cfg_next.left_unit_length  = cfg_data[3:0];
                CFG_RIGHT_UNIT_CHARS:  cfg_next.right_unit_chars  = cfg_data;
                CFG_RIGHT_UNIT_LENGTH: cfg_next.right_unit_length = cfg_data[3:0];
                CFG_UNIT_COPIES:       cfg_next.unit_copies       = cfg_data[6:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_read_length   <= '0;
            cfg_reg.max_mean_error    <= PROB_W'(64'd1 << PROB_FRAC_BITS);
            cfg_reg.left_unit_chars   <= '0;
            cfg_reg.left_unit_length  <= '0;
            cfg_reg.right_unit_chars  <= '0;
            cfg_reg.right_unit_length <= '0;
            cfg_reg.unit_copies       <= 7'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/rqmf_front.sv
// ----------------------------------------------------------------------------
// rqmf_front: per-base accumulation and motif matching
// Counts bases, adds up error probabilities and runs the two Shift-And
// matchers. On the last base of a read it hands the totals to the queue.
// ----------------------------------------------------------------------------
module rqmf_front #(
    parameter int MAX_PATTERN_LEN = rqmf_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rqmf_pkg::cfg_t          cfg,
    input  logic                    base_valid,
    output logic                    base_stall,
    input  rqmf_pkg::base_beat_t    base_beat,
    input  logic                    queue_full,
    output logic                    push,
    output rqmf_pkg::read_totals_t  push_data
);
    import rqmf_pkg::*;

    localparam int IDX_W = $clog2(MAX_PATTERN_LEN);

    // One step of a Shift-And matcher; the top bit of the result is the hit.
    function automatic logic [MAX_PATTERN_LEN:0] shift_and_step(
        input logic [MAX_PATTERN_LEN-1:0] d,
        input logic [63:0]                unit,
        input logic [3:0]                 len,
        input logic [6:0]                 copies,
        input logic [7:0]                 c
    );
        logic [3:0]                 l;
        logic [6:0]                 n;
        logic [9:0]                 m;
        logic [MAX_UNIT_LEN-1:0]    eq;
        logic [MAX_PATTERN_LEN-1:0] mask;
        logic [MAX_PATTERN_LEN-1:0] dn;
        logic [2:0]                 sel;
        logic [IDX_W-1:0]           top_idx;
        logic                       hit;
        l = (len > 4'(MAX_UNIT_LEN)) ? 4'(MAX_UNIT_LEN) : len;
        n = (copies == 7'd0) ? 7'd1 : copies;
        m = 10'(l) * 10'(n);
        for (int k = 0; k < MAX_UNIT_LEN; k++)
        begin
            eq[k] = (unit[8*k +: 8] == c);
        end
        mask = '0;
        for (int j = 0; j < MAX_PATTERN_LEN; j++)
        begin
            // Position j of the pattern repeats unit character j mod l.
            case (l)
                4'd1:    sel = 3'd0;
                4'd2:    sel = 3'(j % 2);
                4'd3:    sel = 3'(j % 3);
                4'd4:    sel = 3'(j % 4);
                4'd5:    sel = 3'(j % 5);
                4'd6:    sel = 3'(j % 6);
                4'd7:    sel = 3'(j % 7);
                4'd8:    sel = 3'(j % 8);
                default: sel = 3'd0;
            endcase
            mask[j] = (10'(j) < m) && eq[sel];
        end
        dn      = {d[MAX_PATTERN_LEN-2:0], 1'b1} & mask;
        top_idx = IDX_W'(m - 10'd1);
        hit     = dn[top_idx];
        // An empty unit or a pattern too long for the matcher never matches.
        if ((l == 4'd0) || (m > 10'(MAX_PATTERN_LEN)))
        begin
            dn  = '0;
            hit = 1'b0;
        end
        return {hit, dn};
    endfunction

    logic [MAX_PATTERN_LEN-1:0] left_bits_reg;
    logic [MAX_PATTERN_LEN-1:0] left_bits_next;
    logic [MAX_PATTERN_LEN-1:0] right_bits_reg;
    logic [MAX_PATTERN_LEN-1:0] right_bits_next;
    logic                       left_seen_reg;
    logic                       left_seen_next;
    logic                       right_seen_reg;
    logic                       right_seen_next;
    logic [COUNT_W-1:0]         base_count_reg;
    logic [COUNT_W-1:0]         base_count_next;
    logic [SUM_W-1:0]           error_sum_reg;
    logic [SUM_W-1:0]           error_sum_next;

    logic                       accept;
    logic [7:0]                 qual_off;
    logic [6:0]                 phred;
    logic [PROB_W-1:0]          prob;
    logic [SUM_W:0]             sum_wide;
    logic [MAX_PATTERN_LEN:0]   left_step;
    logic [MAX_PATTERN_LEN:0]   right_step;
    logic [SUM_W-1:0]           sum_upd;
    logic [COUNT_W-1:0]         count_upd;

    // Input stalls only while the queue has no room.
    assign base_stall = queue_full;
    assign accept     = base_valid && !base_stall;

    // Phred score, clamped, and its error probability.
    assign qual_off = base_beat.quality_char - PHRED_OFFSET;
    always_comb
    begin
        if (base_beat.quality_char < PHRED_OFFSET)
        begin
            phred = 7'd0;
        end
        else if (qual_off > PHRED_TOP)
        begin
            phred = 7'(PHRED_TOP);
        end
        else
        begin
            phred = qual_off[6:0];
        end
    end
    assign prob = ERROR_ROM[phred];

    // Saturating sum and count.
    assign sum_wide  = {1'b0, error_sum_reg} + (SUM_W + 1)'(prob);
    assign sum_upd   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign count_upd = (base_count_reg < MAX_READ_LEN) ? base_count_reg + 1'b1
                                                        : base_count_reg;

    // Motif matchers.
    assign left_step  = shift_and_step(left_bits_reg, cfg.left_unit_chars,
                                       cfg.left_unit_length, cfg.unit_copies,
                                       base_beat.base_char);
    assign right_step = shift_and_step(right_bits_reg, cfg.right_unit_chars,
                                       cfg.right_unit_length, cfg.unit_copies,
                                       base_beat.base_char);

    // Totals of the read as they stand after this base.
    assign push                 = accept && base_beat.last_base;
    assign push_data.base_count = count_upd;
    assign push_data.error_sum  = sum_upd;
    assign push_data.left_seen  = left_seen_reg || left_step[MAX_PATTERN_LEN];
    assign push_data.right_seen = right_seen_reg || right_step[MAX_PATTERN_LEN];

    // Read state update; a last base clears it for the next read.
    always_comb
    begin
        left_bits_next  = left_bits_reg;
        right_bits_next = right_bits_reg;
        left_seen_next  = left_seen_reg;
        right_seen_next = right_seen_reg;
        base_count_next = base_count_reg;
        error_sum_next  = error_sum_reg;
        if (accept)
        begin
            if (base_beat.last_base)
            begin
                left_bits_next  = '0;
                right_bits_next = '0;
                left_seen_next  = 1'b0;
                right_seen_next = 1'b0;
                base_count_next = '0;
                error_sum_next  = '0;
            end
            else
            begin
                left_bits_next  = left_step[MAX_PATTERN_LEN-1:0];
                right_bits_next = right_step[MAX_PATTERN_LEN-1:0];
                left_seen_next  = push_data.left_seen;
                right_seen_next = push_data.right_seen;
                base_count_next = count_upd;
                error_sum_next  = sum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_bits_reg  <= '0;
            right_bits_reg <= '0;
            left_seen_reg  <= 1'b0;
            right_seen_reg <= 1'b0;
            base_count_reg <= '0;
            error_sum_reg  <= '0;
        end
        else
        begin
            left_bits_reg  <= left_bits_next;
            right_bits_reg <= right_bits_next;
            left_seen_reg  <= left_seen_next;
            right_seen_reg <= right_seen_next;
            base_count_reg <= base_count_next;
            error_sum_reg  <= error_sum_next;
        end
    end

    // A read's last beat leaves the front empty for the next read.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (base_count_reg == '0) && !left_seen_reg && !right_seen_reg
                 && (error_sum_reg == '0))
        else $error("read state not cleared after last base");

endmodule

// File: hdl/rqmf_queue.sv
// ----------------------------------------------------------------------------
// rqmf_queue: short queue of read totals
// Decouples the per-base front from the verdict back end.
// ----------------------------------------------------------------------------
module rqmf_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = rqmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

// File: hdl/rqmf_back.sv
// ----------------------------------------------------------------------------
// rqmf_back: verdict of a finished read
// Forms the length limit product in two partial products, compares it with
// the error sum and holds the verdict in an output register.
// ----------------------------------------------------------------------------
module rqmf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rqmf_pkg::cfg_t          cfg,
    input  logic                    queue_empty,
    output logic                    pop,
    input  rqmf_pkg::read_totals_t  pop_data,
    output logic                    verdict_valid,
    input  logic                    verdict_stall,
    output rqmf_pkg::verdict_t      verdict
);
    import rqmf_pkg::*;

    localparam int HALF_W = 20;
    localparam int LO_W   = COUNT_W + HALF_W;
    localparam int HI_W   = COUNT_W + PROB_W - HALF_W;
    localparam int RHS_W  = HI_W + HALF_W;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    read_totals_t       s1_tot_reg;
    logic               s1_len_ok_reg;
    logic [LO_W-1:0]    s1_lo_reg;
    logic [HI_W-1:0]    s1_hi_reg;
    logic               verdict_valid_reg;
    logic               verdict_valid_next;
    verdict_t           verdict_reg;
    verdict_t           verdict_next;

    logic               adv_out;
    logic               adv_s1;
    logic               len_ok;
    logic [RHS_W-1:0]   rhs;
    logic               qual_ok;
    logic               motif_on;

    // Stage advance: the output register frees when taken or empty.
    assign adv_out = !verdict_valid_reg || !verdict_stall;
    assign adv_s1  = !s1_valid_reg || adv_out;
    assign pop     = !queue_empty && adv_s1;

    // Stage 1: length check and partial products of count times limit.
    assign len_ok = (cfg.min_read_length == '0) ||
                    (pop_data.base_count >= cfg.min_read_length);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_tot_reg    <= pop_data;
            s1_len_ok_reg <= len_ok;
            s1_lo_reg     <= LO_W'(pop_data.base_count) *
                             LO_W'(cfg.max_mean_error[HALF_W-1:0]);
            s1_hi_reg     <= HI_W'(pop_data.base_count) *
                             HI_W'(cfg.max_mean_error[PROB_W-1:HALF_W]);
        end
    end

    // Stage 2: exact quality compare and the keep decision.
    assign rhs      = {s1_hi_reg[HI_W-1:0], HALF_W'(0)} + RHS_W'(s1_lo_reg);
    assign qual_ok  = (s1_tot_reg.error_sum <= SUM_W'(rhs));
    assign motif_on = (cfg.left_unit_length != 4'd0) && (cfg.right_unit_length != 4'd0);

    always_comb
    begin
        verdict_next.keep_read   = s1_len_ok_reg && qual_ok &&
                                   (!motif_on || s1_tot_reg.left_seen ||
                                    s1_tot_reg.right_seen);
        verdict_next.read_length = s1_tot_reg.base_count;
        verdict_next.length_ok   = s1_len_ok_reg;
        verdict_next.quality_ok  = qual_ok;
        verdict_next.left_found  = s1_tot_reg.left_seen;
        verdict_next.right_found = s1_tot_reg.right_seen;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && s1_valid_reg)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // Valid flags of the two stages.
    assign s1_valid_next      = adv_s1 ? pop : s1_valid_reg;
    assign verdict_valid_next = adv_out ? s1_valid_reg : verdict_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            verdict_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            verdict_valid_reg <= verdict_valid_next;
        end
    end

    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

    // A verdict in stage 1 moves on whenever the output register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !verdict_valid_reg) |=> verdict_valid_reg)
        else $error("verdict held back from an empty output register");

endmodule

// File: hdl/read_quality_motif_filter_unit.sv
// ----------------------------------------------------------------------------
// read_quality_motif_filter_unit: read length, mean quality and motif filter
// Streams a read one base per beat and gives one verdict beat per read.
//
//   Channel   Handshake              Payload
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (register write)
//   base      base_valid/base_stall  base_beat (base, quality, last flag)
//   verdict   verdict_valid/_stall   verdict (keep, length, flags)
//
// One base beat is taken every cycle while base_stall is low; the error
// accumulator and the match registers of the front update on each base taken.
// A read's totals go through the queue, stage 1 and the output register.
// Reset clears all read state and loads the register defaults; no sweep.
// A stalled verdict is held in the output register; two reads in the queue
// and one in the back stage are absorbed before base_stall rises.
// ----------------------------------------------------------------------------
module read_quality_motif_filter_unit #(
    parameter int MAX_PATTERN_LEN = rqmf_pkg::MAX_PATTERN_LEN_DEF,
    parameter int QUEUE_DEPTH     = rqmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rqmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rqmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             base_valid,
    output logic                             base_stall,
    input  rqmf_pkg::base_beat_t             base_beat,
    output logic                             verdict_valid,
    input  logic                             verdict_stall,
    output rqmf_pkg::verdict_t               verdict
);
    import rqmf_pkg::*;

    cfg_t          cfg;
    logic          push;
    read_totals_t  push_data;
    logic          pop;
    read_totals_t  pop_data;
    logic          queue_full;
    logic          queue_empty;

    // Configuration registers.
    rqmf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Per-base front.
    rqmf_front #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .base_valid (base_valid),
        .base_stall (base_stall),
        .base_beat  (base_beat),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Queue of finished reads.
    rqmf_queue #(
        .WIDTH ($bits(read_totals_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Verdict back end.
    rqmf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .pop_data      (pop_data),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .verdict       (verdict)
    );

endmodule
